// ===== hdl/jscd_pkg.sv =====
// ----------------------------------------------------------------------------
// jscd_pkg
// Shared constants, codes and payload types for the job-shop chromosome
// decoder.
// ----------------------------------------------------------------------------
package jscd_pkg;

  localparam int MAX_JOBS     = 16;
  localparam int MAX_MACHINES = 16;
  localparam int MAX_TASKS    = 256;

  localparam int JOB_IW  = $clog2(MAX_JOBS);
  localparam int MACH_IW = $clog2(MAX_MACHINES);
  localparam int TASK_IW = $clog2(MAX_TASKS);

  localparam int TIME_W  = 32;
  localparam int DUR_W   = 16;
  localparam int CHROM_W = 16;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // request action codes
  localparam logic [1:0] ACT_LOAD_TASK = 2'd0;
  localparam logic [1:0] ACT_LOAD_JOB  = 2'd1;
  localparam logic [1:0] ACT_GENE      = 2'd2;

  typedef struct packed {
    logic [1:0]       action;
    logic [7:0]       task_index;
    logic [3:0]       job_id;
    logic [3:0]       machine_id;
    logic [DUR_W-1:0] duration;
    logic             last_gene;
  } req_t;

  typedef struct packed {
    logic [7:0]         task_id;
    logic [3:0]         machine_out;
    logic [TIME_W-1:0]  start_time;
    logic [TIME_W-1:0]  finish_time;
    logic [TIME_W-1:0]  makespan;
    logic               end_of_chromosome;
    logic [CHROM_W-1:0] chromosome_number;
    logic [CHROM_W-1:0] best_index;
    logic [TIME_W-1:0]  lowest_makespan;
  } res_t;

  typedef struct packed {
    logic [3:0]       machine;
    logic [DUR_W-1:0] duration;
  } task_entry_t;

  // gene after the task lookup stage
  typedef struct packed {
    logic       valid;
    logic [7:0] task_id;
    logic [3:0] job;
    logic       last;
  } gene_t;

  typedef struct packed {
    logic valid;
    res_t data;
  } result_t;

endpackage

// ===== hdl/job_shop_chromosome_decoder.sv =====
// ----------------------------------------------------------------------------
// job_shop_chromosome_decoder
// Operation-based job-shop chromosome decoder, top level.
// ----------------------------------------------------------------------------
// Load requests (task entry, job first task) take effect at once and give
// no result. A gene request runs down a three-stage pipeline (job lookup
// and task table read, machine ready-time read, schedule and write-back)
// and its result passes the s1 and s2 registers into the output register.
// One request is accepted every cycle while the result side keeps up; a
// held result stalls the whole pipeline. Back-to-back genes on the same
// machine are handled by forwarding the last write of the machine
// ready-time memory. Task and first-task entries must be loaded before
// any gene uses them.
// ----------------------------------------------------------------------------
module job_shop_chromosome_decoder import jscd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req_data,
  output logic res_valid,
  input  logic res_ready,
  output res_t res_data
);

  logic        advance;
  gene_t       s1;
  task_entry_t s1_entry;
  result_t     res;

  assign advance   = !res_valid || res_ready;
  assign req_ready = advance;

  jscd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .req_valid(req_valid),
    .req      (req_data),
    .s1       (s1),
    .s1_entry (s1_entry)
  );

  jscd_timing u_timing (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .s1      (s1),
    .s1_entry(s1_entry),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_data <= res.data;
    end
  end

endmodule

// ===== hdl/jscd_ram.sv =====
// ----------------------------------------------------------------------------
// jscd_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module jscd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/jscd_front.sv =====
// ----------------------------------------------------------------------------
// jscd_front
// Request intake: job first-task and op-count tables, task table memory and
// the task lookup for each gene.
// ----------------------------------------------------------------------------
module jscd_front import jscd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic        req_valid,
  input  req_t        req,
  output gene_t       s1,
  output task_entry_t s1_entry
);

  logic [7:0]        first_task [MAX_JOBS];
  logic [7:0]        op_count [MAX_JOBS];
  logic              fire;
  logic              is_gene;
  logic [JOB_IW-1:0] job_idx;
  logic [7:0]        task_next;
  logic [$bits(task_entry_t)-1:0] entry_rd;

  assign fire      = req_valid && advance;
  assign is_gene   = (req.action == ACT_GENE);
  assign job_idx   = req.job_id[JOB_IW-1:0];
  assign task_next = first_task[job_idx] + op_count[job_idx];

  always_ff @(posedge clk) begin
    if (fire && req.action == ACT_LOAD_JOB) begin
      first_task[job_idx] <= req.task_index;
    end
  end

  // op counts clear on the closing gene itself so that the genes behind it
  // already see a fresh chromosome
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_JOBS; i++) op_count[i] <= '0;
    end else if (fire && is_gene) begin
      if (req.last_gene) begin
        for (int i = 0; i < MAX_JOBS; i++) op_count[i] <= '0;
      end else begin
        op_count[job_idx] <= op_count[job_idx] + 8'd1;
      end
    end
  end

  jscd_ram #(
    .WIDTH($bits(task_entry_t)),
    .DEPTH(MAX_TASKS)
  ) u_task_ram (
    .clk  (clk),
    .we   (fire && req.action == ACT_LOAD_TASK),
    .waddr(req.task_index[TASK_IW-1:0]),
    .wdata({req.machine_id, req.duration}),
    .re   (advance),
    .raddr(task_next[TASK_IW-1:0]),
    .rdata(entry_rd)
  );

  assign s1_entry = task_entry_t'(entry_rd);

  always_ff @(posedge clk) begin
    if (advance) begin
      s1.task_id <= task_next;
      s1.job     <= req.job_id;
      s1.last    <= req.last_gene;
    end
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (advance) begin
      s1.valid <= fire && is_gene;
    end
  end

endmodule

// ===== hdl/jscd_timing.sv =====
// ----------------------------------------------------------------------------
// jscd_timing
// Schedule stage: machine ready-time memory with write forwarding, job ready
// times, running makespan and best-chromosome tracking.
// ----------------------------------------------------------------------------
module jscd_timing import jscd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  gene_t       s1,
  input  task_entry_t s1_entry,
  output result_t     res
);

  logic                s2_valid;
  logic [7:0]          s2_task;
  logic [3:0]          s2_job;
  logic [3:0]          s2_mach;
  logic [DUR_W-1:0]    s2_dur;
  logic                s2_last;

  logic [TIME_W-1:0]   job_ready [MAX_JOBS];
  logic [MAX_MACHINES-1:0] mvalid;
  logic [TIME_W-1:0]   mr_mem;
  logic                fwd_valid;
  logic [MACH_IW-1:0]  fwd_m;
  logic [TIME_W-1:0]   fwd_val;

  logic [TIME_W-1:0]   running_makespan;
  logic [CHROM_W-1:0]  chromosome_count;
  logic [TIME_W-1:0]   best_span;
  logic [CHROM_W-1:0]  best_chromosome;

  logic                commit;
  logic [JOB_IW-1:0]   j_idx;
  logic [MACH_IW-1:0]  m_idx;
  logic [TIME_W-1:0]   jr;
  logic [TIME_W-1:0]   mr;
  logic [TIME_W-1:0]   start;
  logic [TIME_W:0]     sum;
  logic [TIME_W-1:0]   finish;
  logic [TIME_W-1:0]   span_next;
  logic                take_best;
  logic [TIME_W-1:0]   best_span_next;
  logic [CHROM_W-1:0]  best_chrom_next;

  assign commit = advance && s2_valid;
  assign j_idx  = s2_job[JOB_IW-1:0];
  assign m_idx  = s2_mach[MACH_IW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_task <= s1.task_id;
      s2_job  <= s1.job;
      s2_mach <= s1_entry.machine;
      s2_dur  <= s1_entry.duration;
      s2_last <= s1.last;
    end
  end

  jscd_ram #(
    .WIDTH(TIME_W),
    .DEPTH(MAX_MACHINES)
  ) u_mach_ram (
    .clk  (clk),
    .we   (commit),
    .waddr(m_idx),
    .wdata(finish),
    .re   (advance),
    .raddr(s1_entry.machine[MACH_IW-1:0]),
    .rdata(mr_mem)
  );

  // the read was issued on the edge that also took the previous commit
  always_comb begin
    if (fwd_valid && fwd_m == m_idx) begin
      mr = fwd_val;
    end else if (mvalid[m_idx]) begin
      mr = mr_mem;
    end else begin
      mr = '0;
    end
  end

  assign jr     = job_ready[j_idx];
  assign start  = (jr > mr) ? jr : mr;
  assign sum    = {1'b0, start} + {{(TIME_W + 1 - DUR_W){1'b0}}, s2_dur};
  assign finish = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
  assign span_next = (finish > running_makespan) ? finish : running_makespan;
  assign take_best = s2_last && (span_next < best_span);
  assign best_span_next  = take_best ? span_next : best_span;
  assign best_chrom_next = take_best ? chromosome_count : best_chromosome;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (advance) begin
      fwd_valid <= s2_valid && !s2_last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fwd_m   <= m_idx;
      fwd_val <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mvalid           <= '0;
      running_makespan <= '0;
      chromosome_count <= '0;
      best_span        <= TIME_MAX;
      best_chromosome  <= '0;
      for (int i = 0; i < MAX_JOBS; i++) job_ready[i] <= '0;
    end else if (commit) begin
      if (s2_last) begin
        mvalid           <= '0;
        running_makespan <= '0;
        chromosome_count <= chromosome_count + CHROM_W'(1);
        best_span        <= best_span_next;
        best_chromosome  <= best_chrom_next;
        for (int i = 0; i < MAX_JOBS; i++) job_ready[i] <= '0;
      end else begin
        mvalid[m_idx]    <= 1'b1;
        running_makespan <= span_next;
        job_ready[j_idx] <= finish;
      end
    end
  end

  always_comb begin
    res.valid                  = s2_valid;
    res.data.task_id           = s2_task;
    res.data.machine_out       = s2_mach;
    res.data.start_time        = start;
    res.data.finish_time       = finish;
    res.data.makespan          = span_next;
    res.data.end_of_chromosome = s2_last;
    res.data.chromosome_number = chromosome_count;
    res.data.best_index        = best_chrom_next;
    res.data.lowest_makespan   = best_span_next;
  end

  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    commit && s2_last |=> running_makespan == '0 && mvalid == '0 && !fwd_valid)
    else $error("chromosome state not cleared after closing gene");

  a_best_monotone: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> best_span <= $past(best_span))
    else $error("best makespan grew");

  a_fwd_valid_entry: assert property (@(posedge clk) disable iff (rst)
    fwd_valid |-> mvalid[fwd_m])
    else $error("forwarded machine entry not marked valid");

  a_finish_order: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> finish >= start && span_next >= finish)
    else $error("finish time below start or makespan");

endmodule

// ===== tb/tb_job_shop_chromosome_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_job_shop_chromosome_decoder
// Self-checking bench for the job-shop chromosome decoder. Requests load the
// task and first-task tables and decode genes. A schedule predictor runs on
// every accepted request and queues the operation it expects for each gene;
// each result is checked field by field against the oldest entry. Covers a
// directed schedule (next task wrapping past 255, makespan tie and improvement,
// the unused action), a run of one-gene chromosomes with falling and tied
// makespans, one job long enough to wrap its op count, and random schedules.
// ----------------------------------------------------------------------------
module tb_job_shop_chromosome_decoder;
  import jscd_pkg::*;

  localparam logic [1:0] ACT_UNUSED   = 2'd3;
  localparam int         STALL_LIMIT  = 1000;
  localparam int         DRAIN_CYCLES = 10;
  localparam int         PRINT_LIMIT  = 50;
  localparam int         RANDOM_GENES = 700;
  localparam int         CHROM_RUNS   = 100;
  localparam int         WRAP_GENES   = 260;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req_data  = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res_data;

  job_shop_chromosome_decoder uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  always #5 clk = ~clk;

  // schedule predictor state
  logic [3:0]         tab_mach   [MAX_TASKS];
  logic [DUR_W-1:0]   tab_dur    [MAX_TASKS];
  bit                 tab_loaded [MAX_TASKS];
  logic [7:0]         job_first  [MAX_JOBS];
  bit                 job_loaded [MAX_JOBS];
  logic [7:0]         job_ops    [MAX_JOBS];
  logic [TIME_W-1:0]  job_free   [MAX_JOBS];
  logic [TIME_W-1:0]  mach_free  [MAX_MACHINES];
  logic [TIME_W-1:0]  span;
  logic [CHROM_W-1:0] chrom_idx;
  logic [TIME_W-1:0]  best_span;
  logic [CHROM_W-1:0] best_chrom;

  res_t scheduled_ops[$];
  int   errors       = 0;
  int   stall_cycles = 0;
  bit   quiet        = 1'b0;

  task automatic restart_chromosome();
    for (int j = 0; j < MAX_JOBS; j++) begin
      job_ops[j]  = '0;
      job_free[j] = '0;
    end
    for (int m = 0; m < MAX_MACHINES; m++) mach_free[m] = '0;
    span = '0;
  endtask

  task automatic init_schedule();
    for (int t = 0; t < MAX_TASKS; t++) begin
      tab_mach[t]   = '0;
      tab_dur[t]    = '0;
      tab_loaded[t] = 1'b0;
    end
    for (int j = 0; j < MAX_JOBS; j++) begin
      job_first[j]  = '0;
      job_loaded[j] = 1'b0;
    end
    restart_chromosome();
    chrom_idx  = '0;
    best_span  = TIME_MAX;
    best_chrom = '0;
  endtask

  task automatic apply_to_schedule(input req_t r);
    logic [7:0]        tid;
    logic [3:0]        m;
    logic [TIME_W-1:0] start;
    logic [TIME_W:0]   sum;
    res_t              op;
    case (r.action)
      ACT_LOAD_TASK: begin
        tab_mach[r.task_index]   = r.machine_id;
        tab_dur[r.task_index]    = r.duration;
        tab_loaded[r.task_index] = 1'b1;
      end
      ACT_LOAD_JOB: begin
        job_first[r.job_id]  = r.task_index;
        job_loaded[r.job_id] = 1'b1;
      end
      ACT_GENE: begin
        tid   = job_first[r.job_id] + job_ops[r.job_id];
        m     = tab_mach[tid];
        start = (job_free[r.job_id] > mach_free[m]) ? job_free[r.job_id] : mach_free[m];
        sum   = {1'b0, start} + tab_dur[tid];
        op.task_id     = tid;
        op.machine_out = m;
        op.start_time  = start;
        op.finish_time = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
        job_ops[r.job_id]  = job_ops[r.job_id] + 8'd1;
        job_free[r.job_id] = op.finish_time;
        mach_free[m]       = op.finish_time;
        if (op.finish_time > span) span = op.finish_time;
        op.makespan          = span;
        op.end_of_chromosome = r.last_gene;
        op.chromosome_number = chrom_idx;
        if (r.last_gene) begin
          // strict compare: earlier chromosome keeps a tie
          if (span < best_span) begin
            best_span  = span;
            best_chrom = chrom_idx;
          end
          restart_chromosome();
          chrom_idx = chrom_idx + CHROM_W'(1);
        end
        op.best_index      = best_chrom;
        op.lowest_makespan = best_span;
        scheduled_ops.insert(scheduled_ops.size(), op);
      end
      default: ;
    endcase
  endtask

  // request builders; fields a request ignores carry random bits
  function automatic req_t rand_req();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(req_t)-1:0];
  endfunction

  function automatic logic [DUR_W-1:0] rand_duration();
    if ($urandom_range(99) < 60) return DUR_W'($urandom_range(255));
    return DUR_W'($urandom);
  endfunction

  function automatic req_t task_load_req(input logic [7:0] t, input logic [3:0] m,
                                         input logic [DUR_W-1:0] d);
    req_t r;
    r            = rand_req();
    r.action     = ACT_LOAD_TASK;
    r.task_index = t;
    r.machine_id = m;
    r.duration   = d;
    return r;
  endfunction

  function automatic req_t job_load_req(input logic [3:0] j, input logic [7:0] t);
    req_t r;
    r            = rand_req();
    r.action     = ACT_LOAD_JOB;
    r.job_id     = j;
    r.task_index = t;
    return r;
  endfunction

  function automatic req_t gene_req(input logic [3:0] j, input logic last);
    req_t r;
    r           = rand_req();
    r.action    = ACT_GENE;
    r.job_id    = j;
    r.last_gene = last;
    return r;
  endfunction

  // called at a rising edge; leaves valid high so the next request can follow
  task automatic send_request(input req_t r);
    if (!quiet && $urandom_range(99) < 15) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    do @(posedge clk); while (!req_ready);
    apply_to_schedule(r);
  endtask

  task automatic hold_until_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (scheduled_ops.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= PRINT_LIMIT)
      $display("%0t: %s got %h expected %h", $time, what, got, want);
  endtask

  // result checker
  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && res_ready) begin
      if (scheduled_ops.size() == 0) begin
        report_mismatch("result with nothing pending, task_id", res_data.task_id, '0);
      end else begin
        want = scheduled_ops.pop_front();
        if (res_data.task_id !== want.task_id)
          report_mismatch("task_id", res_data.task_id, want.task_id);
        if (res_data.machine_out !== want.machine_out)
          report_mismatch("machine_out", res_data.machine_out, want.machine_out);
        if (res_data.start_time !== want.start_time)
          report_mismatch("start_time", res_data.start_time, want.start_time);
        if (res_data.finish_time !== want.finish_time)
          report_mismatch("finish_time", res_data.finish_time, want.finish_time);
        if (res_data.makespan !== want.makespan)
          report_mismatch("makespan", res_data.makespan, want.makespan);
        if (res_data.end_of_chromosome !== want.end_of_chromosome)
          report_mismatch("end_of_chromosome", res_data.end_of_chromosome,
                          want.end_of_chromosome);
        if (res_data.chromosome_number !== want.chromosome_number)
          report_mismatch("chromosome_number", res_data.chromosome_number,
                          want.chromosome_number);
        if (res_data.best_index !== want.best_index)
          report_mismatch("best_index", res_data.best_index, want.best_index);
        if (res_data.lowest_makespan !== want.lowest_makespan)
          report_mismatch("lowest_makespan", res_data.lowest_makespan,
                          want.lowest_makespan);
      end
    end
  end

  always @(posedge clk) begin
    res_ready <= quiet || ($urandom_range(99) >= 15);
  end

  // cycles with work outstanding but no handshake on either side
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (res_valid && res_ready))
      stall_cycles <= 0;
    else if (req_valid || scheduled_ops.size() != 0)
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("** job_shop_chromosome_decoder: FAILED **");
    $finish;
  end

  task automatic test_directed();
    req_t r;
    send_request(task_load_req(8'd0,   4'd0,  16'h0000));
    send_request(task_load_req(8'd255, 4'd15, 16'hFFFF));
    send_request(task_load_req(8'd254, 4'd15, 16'h0100));
    send_request(task_load_req(8'd1,   4'd5,  16'h8001));
    send_request(job_load_req(4'd0,  8'd254));
    send_request(job_load_req(4'd15, 8'd255));
    send_request(job_load_req(4'd7,  8'd1));
    r        = rand_req();
    r.action = ACT_UNUSED;
    send_request(r);
    // job 15's second op wraps from task 255 to task 0; second pass ties
    repeat (2) begin
      send_request(gene_req(4'd0,  1'b0));
      send_request(gene_req(4'd15, 1'b0));
      send_request(gene_req(4'd15, 1'b0));
      send_request(gene_req(4'd7,  1'b0));
      send_request(gene_req(4'd0,  1'b1));
    end
    send_request(gene_req(4'd15, 1'b1));
  endtask

  // one-gene chromosomes with falling makespans; each pair ties
  task automatic test_best_tracking();
    send_request(job_load_req(4'd1, 8'd2));
    for (int k = 0; k < CHROM_RUNS; k++) begin
      send_request(task_load_req(8'd2, 4'($urandom_range(15)), DUR_W'(65535 - k / 2)));
      send_request(gene_req(4'd1, 1'b1));
    end
  endtask

  // one job runs through every task entry and past it: task id and op count wrap
  task automatic test_op_count_wrap();
    quiet = 1'b1;
    for (int t = 0; t < MAX_TASKS; t++)
      send_request(task_load_req(8'(t), 4'd3, 16'hFFFF));
    send_request(job_load_req(4'd4, 8'd200));
    for (int n = 0; n < WRAP_GENES; n++)
      send_request(gene_req(4'd4, n == WRAP_GENES - 1));
    quiet = 1'b0;
  endtask

  task automatic test_random_schedules();
    int         genes;
    int         len;
    logic [3:0] j;
    logic [7:0] need;
    req_t       r;
    for (int t = 0; t < MAX_TASKS; t++)
      send_request(task_load_req(8'(t), 4'($urandom_range(15)), rand_duration()));
    for (int k = 0; k < MAX_JOBS; k++)
      send_request(job_load_req(4'(k), 8'($urandom_range(255))));
    genes = 0;
    while (genes < RANDOM_GENES) begin
      len = $urandom_range(1, 12);
      for (int g = 0; g < len; g++) begin
        quiet = (genes >= 300 && genes < 500);
        if ($urandom_range(99) < 8) begin
          if ($urandom_range(1))
            send_request(task_load_req(8'($urandom), 4'($urandom), rand_duration()));
          else
            send_request(job_load_req(4'($urandom), 8'($urandom)));
        end
        if ($urandom_range(99) < 3) begin
          r        = rand_req();
          r.action = ACT_UNUSED;
          send_request(r);
        end
        j = 4'($urandom_range(15));
        if (!job_loaded[j]) send_request(job_load_req(j, 8'($urandom)));
        need = job_first[j] + job_ops[j];
        if (!tab_loaded[need])
          send_request(task_load_req(need, 4'($urandom), rand_duration()));
        send_request(gene_req(j, g == len - 1));
        genes++;
        if (genes % 250 == 0) hold_until_drained();
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    init_schedule();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_best_tracking();
    test_op_count_wrap();
    test_random_schedules();
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("** job_shop_chromosome_decoder: PASSED **");
    else
      $display("** job_shop_chromosome_decoder: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/jscd_pkg.sv
hdl/jscd_ram.sv
hdl/jscd_front.sv
hdl/jscd_timing.sv
hdl/job_shop_chromosome_decoder.sv
tb/tb_job_shop_chromosome_decoder.sv
